@@ rtl/core/sdcr_pkg.sv @@
// ----------------------------------------------------------------------------
// sdcr_pkg
// Shared constants for the stereo DC offset remover.
// ----------------------------------------------------------------------------
package sdcr_pkg;

  localparam int unsigned FRAME_SAMPLES = 64;
  localparam int unsigned POS_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

  localparam logic [31:0] CORR_RESET = 32'(1230) << 16;
  localparam logic signed [15:0] PEAK_RESET = 16'sh8000;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_SAMPLES - 1);
  localparam logic [31:0] FRAME_STEP = 32'(FRAME_SAMPLES);

endpackage

@@ rtl/core/sdcr_if.sv @@
// ----------------------------------------------------------------------------
// sdcr_if
// Valid/ready channels of the stereo DC offset remover.
// ----------------------------------------------------------------------------
interface sdcr_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface sdcr_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] corrected_left;
  logic signed [15:0] corrected_right;
  logic signed [15:0] peak_level;
  logic frame_end;
  logic [31:0] sample_count;

  modport source (output valid, corrected_left, corrected_right, peak_level,
                  frame_end, sample_count, input ready);
  modport sink (input valid, corrected_left, corrected_right, peak_level,
                frame_end, sample_count, output ready);
endinterface

interface sdcr_cfg_if;
  logic valid;
  logic ready;
  logic correction_enable;

  modport source (output valid, correction_enable, input ready);
  modport sink (input valid, correction_enable, output ready);
endinterface

@@ rtl/core/stereo_dc_offset_remover_peak.sv @@
// ----------------------------------------------------------------------------
// stereo_dc_offset_remover_peak
// Per-frame feedback DC offset removal on a stereo sample stream, with
// a running peak over both corrected channels and a sample total.
//
// samples: one request carries a left and a right 16-bit sample.
// results: one request per sample: both corrected samples, the running
//   peak including this sample, a frame end flag and the sample total.
// ctrl: writes correction_enable; always ready, write only while idle.
// The result is registered and valid in the cycle after sample acceptance.
// One sample is taken every cycle while results are taken, as the single
// result register sets that figure. samples.ready stays high while the
// result register is empty or being taken, so a stalled receiver holds one
// result and then stops intake. At reset both corrections load 1230 in the
// upper half, sums, frame position and total clear, the peak starts at
// -32768, correction is enabled and the result register empties.
// ----------------------------------------------------------------------------
module stereo_dc_offset_remover_peak
  import sdcr_pkg::*;
(
  input logic clk,
  input logic rst,
  sdcr_in_if.sink samples,
  sdcr_out_if.source results,
  sdcr_cfg_if.sink ctrl
);

  logic enable;
  logic [31:0] left_corr;
  logic [31:0] right_corr;
  logic [31:0] left_sum;
  logic [31:0] right_sum;
  logic [POS_W-1:0] pos;
  logic signed [15:0] peak;
  logic [31:0] total;

  logic out_valid;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic signed [15:0] out_peak;
  logic out_fend;
  logic [31:0] out_total;

  logic accept;
  logic signed [15:0] left_c;
  logic signed [15:0] right_c;
  logic signed [15:0] peak_a;
  logic signed [15:0] peak_next;
  logic [31:0] left_sum_next;
  logic [31:0] right_sum_next;
  logic fend;
  logic [31:0] total_next;

  assign samples.ready = !out_valid || results.ready;
  assign accept = samples.valid && samples.ready;
  assign ctrl.ready = 1'b1;

  always_comb begin
    if (enable) begin
      left_c = samples.left_sample + $signed(left_corr[31:16]);
      right_c = samples.right_sample + $signed(right_corr[31:16]);
      left_sum_next = left_sum + 32'(left_c);
      right_sum_next = right_sum + 32'(right_c);
    end else begin
      left_c = samples.left_sample;
      right_c = samples.right_sample;
      left_sum_next = left_sum;
      right_sum_next = right_sum;
    end
    peak_a = (left_c > peak) ? left_c : peak;
    peak_next = (right_c > peak_a) ? right_c : peak_a;
    fend = (pos == POS_LAST);
    total_next = fend ? total + FRAME_STEP : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      left_corr <= CORR_RESET;
      right_corr <= CORR_RESET;
      left_sum <= '0;
      right_sum <= '0;
      pos <= '0;
      peak <= PEAK_RESET;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.valid) begin
        enable <= ctrl.correction_enable;
      end
      if (accept) begin
        peak <= peak_next;
        total <= total_next;
        if (fend) begin
          if (enable) begin
            left_corr <= left_corr - (left_sum_next << 2);
            right_corr <= right_corr - (right_sum_next << 2);
          end
          left_sum <= '0;
          right_sum <= '0;
          pos <= '0;
        end else begin
          left_sum <= left_sum_next;
          right_sum <= right_sum_next;
          pos <= pos + POS_W'(1);
        end
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_left <= left_c;
      out_right <= right_c;
      out_peak <= peak_next;
      out_fend <= fend;
      out_total <= total_next;
    end
  end

  assign results.valid = out_valid;
  assign results.corrected_left = out_left;
  assign results.corrected_right = out_right;
  assign results.peak_level = out_peak;
  assign results.frame_end = out_fend;
  assign results.sample_count = out_total;

endmodule
